// ===== hw/rtl/gtl_pkg.sv =====
// ============================================================================
// gtl_pkg
// Shared types, result codes and character classes of the grammar token lexer.
// ============================================================================
package gtl_pkg;

    // Default widths of the position and length counters.
    localparam int POSITION_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 16;

    // Depth of the result queue in front of the output channel.
    localparam int RESULT_DEPTH = 4;

    // Lexer modes.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_LIT   = 3'd2,
        MODE_ESC   = 3'd3,
        MODE_COLON = 3'd4,
        MODE_PLUS  = 3'd5,
        MODE_ERROR = 3'd6
    } mode_t;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Token kinds.
    localparam logic [3:0] TOK_IDENT   = 4'd0;
    localparam logic [3:0] TOK_LITERAL = 4'd1;
    localparam logic [3:0] TOK_ASSIGN  = 4'd2;
    localparam logic [3:0] TOK_APPEND  = 4'd3;
    localparam logic [3:0] TOK_BAR     = 4'd4;
    localparam logic [3:0] TOK_LPAREN  = 4'd5;
    localparam logic [3:0] TOK_RPAREN  = 4'd6;
    localparam logic [3:0] TOK_STAR    = 4'd7;
    localparam logic [3:0] TOK_PLUS    = 4'd8;
    localparam logic [3:0] TOK_QUEST   = 4'd9;
    localparam logic [3:0] TOK_SEMI    = 4'd10;
    localparam logic [3:0] TOK_BANG    = 4'd11;
    localparam logic [3:0] TOK_TILDE   = 4'd12;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_QUEST     = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR       = 8'h7C;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // One result as it waits in the output queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  token_kind;
        logic [7:0]  value_char;
        logic [15:0] line_no;
        logic [15:0] column_no;
        logic [15:0] token_length;
        logic        last_result;
    } res_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== hw/rtl/grammar_token_lexer_unit.sv =====
// ============================================================================
// grammar_token_lexer_unit
// Streaming lexer for a small grammar notation, one character per transfer.
// ============================================================================
//
// Usage:
// The input channel (in_valid / in_stall) carries one character per transfer
// in char_in, with end_of_text marking the end of a string; a zero character
// also ends the string. The output channel (out_valid / out_stall) carries
// results: value characters of identifiers and literals, token records,
// error results and one end-of-text result per string. last_result marks the
// final result caused by an input character; a character may cause none.
// Every input transfer is decoded in the cycle it is taken, and its zero, one
// or two results are pushed into a four-entry result queue. The first result
// of a character is presented the cycle after its transfer if the queue was empty.
// One character is taken every cycle while the queue holds at most two
// results; the output drains one result per cycle while the receiver does
// not stall.
// When the receiver stalls, the head result holds steady and the queue fills;
// once it holds more than two results the input is stalled.
// Reset empties the queue and puts the lexer in idle with line, column and
// length counters at zero. Line and column persist across strings.
//
module grammar_token_lexer_unit #(
    parameter int POSITION_BITS = gtl_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = gtl_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_of_text,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [3:0]  token_kind,
    output logic [7:0]  value_char,
    output logic [15:0] line_no,
    output logic [15:0] column_no,
    output logic [15:0] token_length,
    output logic        last_result
);

    localparam int DEPTH    = gtl_pkg::RESULT_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Lexer state.
    // ------------------------------------------------------------------
    gtl_pkg::mode_t           mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;

    // Results of the character being taken.
    gtl_pkg::res_t res0, res1;
    logic [1:0]    res_cnt;

    // Result queue.
    gtl_pkg::res_t       queue_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;

    logic accept;
    logic pop;
    logic is_end;

    // Builds one result; positions show their low 16 bits.
    function automatic gtl_pkg::res_t make_res(
        input logic [1:0]               k,
        input logic [3:0]               tk,
        input logic [7:0]               ch,
        input logic [POSITION_BITS-1:0] ln,
        input logic [POSITION_BITS-1:0] cl,
        input logic [LENGTH_BITS-1:0]   len
    );
        gtl_pkg::res_t r;
        logic [31:0]   ln_w;
        logic [31:0]   cl_w;
        logic [31:0]   len_w;
        ln_w           = 32'(ln);
        cl_w           = 32'(cl);
        len_w          = 32'(len);
        r.kind         = k;
        r.token_kind   = tk;
        r.value_char   = ch;
        r.line_no      = ln_w[15:0];
        r.column_no    = cl_w[15:0];
        r.token_length = len_w[15:0];
        r.last_result  = 1'b0;
        return r;
    endfunction

    assign accept   = in_valid && !in_stall;
    assign in_stall = (count_reg > CNT_BITS'(2));
    assign out_valid = (count_reg != '0);
    assign pop      = out_valid && !out_stall;
    assign is_end   = end_of_text || (char_in == gtl_pkg::CH_NUL);

    // ------------------------------------------------------------------
    // Character decode: next state and up to two results.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic                     do_idle;
        logic                     idle_has;
        gtl_pkg::res_t            idle_res;
        logic                     single_hit;
        logic [3:0]               single_tok;
        logic [POSITION_BITS-1:0] col_inc;
        logic [LENGTH_BITS-1:0]   len_inc;

        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;
        do_idle    = 1'b0;
        idle_has   = 1'b0;
        idle_res   = '0;
        col_inc    = (&col_reg) ? col_reg : col_reg + POSITION_BITS'(1);
        len_inc    = (&len_reg) ? len_reg : len_reg + LENGTH_BITS'(1);

        single_hit = 1'b1;
        case (char_in)
            gtl_pkg::CH_BAR:    single_tok = gtl_pkg::TOK_BAR;
            gtl_pkg::CH_LPAREN: single_tok = gtl_pkg::TOK_LPAREN;
            gtl_pkg::CH_RPAREN: single_tok = gtl_pkg::TOK_RPAREN;
            gtl_pkg::CH_STAR:   single_tok = gtl_pkg::TOK_STAR;
            gtl_pkg::CH_QUEST:  single_tok = gtl_pkg::TOK_QUEST;
            gtl_pkg::CH_SEMI:   single_tok = gtl_pkg::TOK_SEMI;
            gtl_pkg::CH_BANG:   single_tok = gtl_pkg::TOK_BANG;
            gtl_pkg::CH_TILDE:  single_tok = gtl_pkg::TOK_TILDE;
            default:
            begin
                single_hit = 1'b0;
                single_tok = gtl_pkg::TOK_IDENT;
            end
        endcase

        if (is_end)
        begin
            // A pending token is closed, or an unfinished one reported as an error, before the end-of-text result.
            if (mode_reg == gtl_pkg::MODE_IDENT)
            begin
                res0    = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_IDENT, 8'd0,
                                   line_reg, col_reg, len_reg);
                res_cnt = 2'd1;
            end
            else if (mode_reg == gtl_pkg::MODE_PLUS)
            begin
                res0    = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_PLUS, 8'd0,
                                   line_reg, col_reg, LENGTH_BITS'(1));
                res_cnt = 2'd1;
            end
            else if ((mode_reg == gtl_pkg::MODE_COLON) || (mode_reg == gtl_pkg::MODE_LIT)
                     || (mode_reg == gtl_pkg::MODE_ESC))
            begin
                col_next = start_reg;
                res0     = make_res(gtl_pkg::KIND_ERROR, 4'd0, 8'd0,
                                    line_reg, start_reg, '0);
                res_cnt  = 2'd1;
            end
            mode_next = gtl_pkg::MODE_IDLE;
            if (res_cnt == 2'd0)
            begin
                res0 = make_res(gtl_pkg::KIND_END, 4'd0, 8'd0, line_reg, col_next, '0);
            end
            else
            begin
                res1 = make_res(gtl_pkg::KIND_END, 4'd0, 8'd0, line_reg, col_next, '0);
            end
            res_cnt = res_cnt + 2'd1;
        end
        else
        begin
            case (mode_reg)
                gtl_pkg::MODE_ERROR:
                begin
                    // Characters are dropped until the end of the string.
                end
                gtl_pkg::MODE_LIT:
                begin
                    if (char_in == gtl_pkg::CH_QUOTE)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_IDLE;
                        res0      = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_LITERAL, 8'd0,
                                             line_reg, col_inc, len_reg);
                        res_cnt   = 2'd1;
                    end
                    else if (char_in == gtl_pkg::CH_BACKSLASH)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_ESC;
                    end
                    else if (char_in == gtl_pkg::CH_NEWLINE)
                    begin
                        col_next  = start_reg;
                        mode_next = gtl_pkg::MODE_ERROR;
                        res0      = make_res(gtl_pkg::KIND_ERROR, 4'd0, 8'd0,
                                             line_reg, start_reg, '0);
                        res_cnt   = 2'd1;
                    end
                    else
                    begin
                        col_next = col_inc;
                        len_next = len_inc;
                        res0     = make_res(gtl_pkg::KIND_VALUE, gtl_pkg::TOK_LITERAL, char_in,
                                            line_reg, col_inc, len_inc);
                        res_cnt  = 2'd1;
                    end
                end
                gtl_pkg::MODE_ESC:
                begin
                    // The escaped character is kept as it is.
                    col_next  = col_inc;
                    len_next  = len_inc;
                    mode_next = gtl_pkg::MODE_LIT;
                    res0      = make_res(gtl_pkg::KIND_VALUE, gtl_pkg::TOK_LITERAL, char_in,
                                         line_reg, col_inc, len_inc);
                    res_cnt   = 2'd1;
                end
                gtl_pkg::MODE_COLON:
                begin
                    if (char_in == gtl_pkg::CH_EQUAL)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_IDLE;
                        res0      = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_ASSIGN, 8'd0,
                                             line_reg, col_inc, LENGTH_BITS'(2));
                    end
                    else
                    begin
                        col_next  = start_reg;
                        mode_next = gtl_pkg::MODE_ERROR;
                        res0      = make_res(gtl_pkg::KIND_ERROR, 4'd0, 8'd0,
                                             line_reg, start_reg, '0);
                    end
                    res_cnt = 2'd1;
                end
                gtl_pkg::MODE_PLUS:
                begin
                    if (char_in == gtl_pkg::CH_EQUAL)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_IDLE;
                        res0      = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_APPEND, 8'd0,
                                             line_reg, col_inc, LENGTH_BITS'(2));
                    end
                    else
                    begin
                        res0      = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_PLUS, 8'd0,
                                             line_reg, col_reg, LENGTH_BITS'(1));
                        mode_next = gtl_pkg::MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                    res_cnt = 2'd1;
                end
                gtl_pkg::MODE_IDENT:
                begin
                    if (gtl_pkg::is_letter(char_in) || gtl_pkg::is_digit(char_in))
                    begin
                        col_next = col_inc;
                        len_next = len_inc;
                        res0     = make_res(gtl_pkg::KIND_VALUE, gtl_pkg::TOK_IDENT, char_in,
                                            line_reg, col_inc, len_inc);
                    end
                    else
                    begin
                        res0      = make_res(gtl_pkg::KIND_RECORD, gtl_pkg::TOK_IDENT, 8'd0,
                                             line_reg, col_reg, len_reg);
                        mode_next = gtl_pkg::MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                    res_cnt = 2'd1;
                end
                default:
                begin
                    mode_next = gtl_pkg::MODE_IDLE;
                    do_idle   = 1'b1;
                end
            endcase

            // Start of a new token, or whitespace, from the idle mode.
            if (do_idle)
            begin
                if ((char_in == gtl_pkg::CH_SPACE) || (char_in == gtl_pkg::CH_TAB))
                begin
                    col_next = col_inc;
                end
                else if (char_in == gtl_pkg::CH_NEWLINE)
                begin
                    line_next = (&line_reg) ? line_reg : line_reg + POSITION_BITS'(1);
                    col_next  = '0;
                end
                else
                begin
                    start_next = col_reg;
                    if (gtl_pkg::is_letter(char_in))
                    begin
                        col_next  = col_inc;
                        len_next  = LENGTH_BITS'(1);
                        mode_next = gtl_pkg::MODE_IDENT;
                        idle_res  = make_res(gtl_pkg::KIND_VALUE, gtl_pkg::TOK_IDENT, char_in,
                                             line_reg, col_inc, LENGTH_BITS'(1));
                        idle_has  = 1'b1;
                    end
                    else if (char_in == gtl_pkg::CH_QUOTE)
                    begin
                        col_next  = col_inc;
                        len_next  = '0;
                        mode_next = gtl_pkg::MODE_LIT;
                    end
                    else if (char_in == gtl_pkg::CH_COLON)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_COLON;
                    end
                    else if (char_in == gtl_pkg::CH_PLUS)
                    begin
                        col_next  = col_inc;
                        mode_next = gtl_pkg::MODE_PLUS;
                    end
                    else if (single_hit)
                    begin
                        col_next = col_inc;
                        idle_res = make_res(gtl_pkg::KIND_RECORD, single_tok, 8'd0,
                                            line_reg, col_inc, LENGTH_BITS'(1));
                        idle_has = 1'b1;
                    end
                    else
                    begin
                        // Unknown character: the column stays at its start.
                        mode_next = gtl_pkg::MODE_ERROR;
                        idle_res  = make_res(gtl_pkg::KIND_ERROR, 4'd0, 8'd0,
                                             line_reg, col_reg, '0);
                        idle_has  = 1'b1;
                    end
                end

                if (idle_has)
                begin
                    if (res_cnt == 2'd0)
                    begin
                        res0 = idle_res;
                    end
                    else
                    begin
                        res1 = idle_res;
                    end
                    res_cnt = res_cnt + 2'd1;
                end
            end
        end

        // Mark the final result of this character.
        if (res_cnt == 2'd1)
        begin
            res0.last_result = 1'b1;
        end
        else if (res_cnt == 2'd2)
        begin
            res1.last_result = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Queue occupancy.
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + CNT_BITS'(res_cnt);
        end
        if (pop)
        begin
            count_next = count_next - CNT_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= gtl_pkg::MODE_IDLE;
            line_reg   <= '0;
            col_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
                start_reg  <= start_next;
                len_reg    <= len_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue storage: the first result goes at the write pointer, the second
    // one entry after it.
    always_ff @(posedge clk)
    begin
        if (accept && (res_cnt != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && (res_cnt == 2'd2))
        begin
            queue_reg[wr_ptr_reg + PTR_BITS'(1)] <= res1;
        end
    end

    assign kind         = queue_reg[rd_ptr_reg].kind;
    assign token_kind   = queue_reg[rd_ptr_reg].token_kind;
    assign value_char   = queue_reg[rd_ptr_reg].value_char;
    assign line_no      = queue_reg[rd_ptr_reg].line_no;
    assign column_no    = queue_reg[rd_ptr_reg].column_no;
    assign token_length = queue_reg[rd_ptr_reg].token_length;
    assign last_result  = queue_reg[rd_ptr_reg].last_result;

`ifndef SYNTHESIS
    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue overflow");

    // After an error, ordinary characters leave line and column untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_end && (mode_reg == gtl_pkg::MODE_ERROR))
        |=> ($stable(line_reg) && $stable(col_reg)))
        else $error("position moved while an error was held");

    // The end of a string always returns the lexer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (mode_reg == gtl_pkg::MODE_IDLE))
        else $error("lexer not idle after end of text");
`endif

endmodule
